@@ design/adsbd_pkg.sv @@
// Package for the DF17 extended squitter field decoder.
// Holds the message class codes, the decode constants, the front-stage bundle
// and the 6-bit character map. No dependencies.
package adsbd_pkg;

  // Downlink format of an extended squitter
  localparam logic [4:0] DF_EXT_SQUITTER = 5'd17;
  // Type code of airborne velocity
  localparam logic [4:0] TC_VELOCITY = 5'd19;

  // Altitude is N * ALT_STEP - ALT_OFFSET feet
  localparam int ALT_STEP = 25;
  localparam int ALT_OFFSET = 1000;
  // Vertical rate step in ft/min, applied as a shift
  localparam int VR_STEP = 64;
  localparam int VR_SHIFT = $clog2(VR_STEP);

  // NIC value for messages without one
  localparam logic [3:0] NIC_NA = 4'd12;

  // Callsign characters with special handling
  localparam logic [7:0] CHAR_DROP = 8'h23;   // '#'
  localparam logic [7:0] CHAR_SPACE = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_ALPHA_BASE = 8'h40;

  localparam int CALL_CHARS = 8;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_IDENT    = 3'd1,
    CLS_SURF_POS = 3'd2,
    CLS_AIR_POS  = 3'd3,
    CLS_VELOCITY = 3'd4,
    CLS_OTHER    = 3'd5
  } msg_class_t;

  // Everything the first stage extracts from one message
  typedef struct packed {
    msg_class_t                       cls;
    logic [4:0]                       tc;
    logic [2:0]                       sub;
    logic [CALL_CHARS-1:0][7:0]       chars;
    logic [CALL_CHARS-1:0]            keep;
    logic                             alt_en;
    logic [10:0]                      alt_n;
    logic [3:0]                       nic;
    logic [16:0]                      lat;
    logic [16:0]                      lon;
    logic                             vel_en;
    logic                             speed_sub;
    logic                             ew_sign;
    logic [9:0]                       ew_raw;
    logic                             ns_sign;
    logic [9:0]                       ns_raw;
    logic                             vr_sign;
    logic [8:0]                       vr_raw;
  } front_t;

  // 6-bit ident code to ASCII; unused codes give '#'
  function automatic logic [7:0] char_of(input logic [5:0] code);
    logic [7:0] ch;
    ch = CHAR_DROP;
    if (code inside {[6'd1:6'd26]}) begin
      ch = CHAR_ALPHA_BASE + {2'b00, code};
    end else if (code == 6'd32) begin
      ch = CHAR_SPACE;
    end else if (code inside {[6'd48:6'd57]}) begin
      // digits: the code equals the ASCII value
      ch = {2'b00, code};
    end
    return ch;
  endfunction

endpackage

@@ design/adsbd_classify.sv @@
// First pipeline stage: message classification and bit slicing.
// Maps the callsign codes, extracts position and velocity raws, derives NIC.
// Depends on adsbd_pkg.
module adsbd_classify
  import adsbd_pkg::*;
(
  input  logic        clk,
  input  logic [7:0]  header,
  input  logic [55:0] payload,
  output front_t      front
);

  front_t front_next;

  // NIC from type code and the supplement-B bit
  function automatic logic [3:0] nic_of(input logic [4:0] tc, input logic supb);
    logic [3:0] n;
    case (tc)
      5'd18:   n = 4'd0;
      5'd17:   n = 4'd1;
      5'd16:   n = supb ? 4'd3 : 4'd2;
      5'd15:   n = 4'd4;
      5'd14:   n = 4'd5;
      5'd13:   n = 4'd6;
      5'd12:   n = 4'd7;
      5'd11:   n = supb ? 4'd9 : 4'd8;
      5'd10:   n = 4'd10;
      5'd9:    n = 4'd11;
      default: n = NIC_NA;
    endcase
    return n;
  endfunction

  // Slice the ME field by class
  always_comb begin
    front_next = '0;
    front_next.cls = CLS_NONE;
    front_next.nic = NIC_NA;
    if (header[7:3] == DF_EXT_SQUITTER) begin
      front_next.tc = payload[55:51];
      if (front_next.tc inside {[5'd1:5'd4]}) begin
        front_next.cls = CLS_IDENT;
        front_next.sub = payload[50:48];
        for (int k = 0; k < CALL_CHARS; k++) begin
          front_next.chars[k] = char_of(payload[47-6*k -: 6]);
          front_next.keep[k] = (front_next.chars[k] != CHAR_DROP);
        end
      end else if (front_next.tc inside {[5'd5:5'd18]}) begin
        front_next.cls = (front_next.tc <= 5'd8) ? CLS_SURF_POS : CLS_AIR_POS;
        front_next.sub = {2'b00, payload[34]};
        front_next.lat = payload[33:17];
        front_next.lon = payload[16:0];
        if (front_next.cls == CLS_AIR_POS) begin
          front_next.alt_en = payload[40];
          front_next.alt_n = {payload[47:41], payload[39:36]};
          front_next.nic = nic_of(front_next.tc, payload[48]);
        end
      end else if (front_next.tc == TC_VELOCITY) begin
        front_next.cls = CLS_VELOCITY;
        front_next.sub = payload[50:48];
        front_next.vel_en = 1'b1;
        front_next.speed_sub = (payload[50:48] == 3'd1) || (payload[50:48] == 3'd2);
        front_next.ew_sign = payload[42];
        front_next.ew_raw = payload[41:32];
        front_next.ns_sign = payload[31];
        front_next.ns_raw = payload[30:21];
        front_next.vr_sign = payload[19];
        front_next.vr_raw = payload[18:10];
      end else begin
        front_next.cls = CLS_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    front <= front_next;
  end

endmodule

@@ design/adsbd_callsign.sv @@
// Callsign compaction, stages two to four: kept-character positions,
// packing into bytes, removal of one trailing '_'.
// Depends on adsbd_pkg.
module adsbd_callsign
  import adsbd_pkg::*;
(
  input  logic                       clk,
  input  logic [CALL_CHARS-1:0][7:0] chars,
  input  logic [CALL_CHARS-1:0]      keep,
  output logic [63:0]                callsign_text,
  output logic [3:0]                 callsign_length
);

  // Stage two registers
  logic [CALL_CHARS-1:0][7:0] chars2;
  logic [CALL_CHARS-1:0]      keep2;
  logic [CALL_CHARS-1:0][2:0] pos2;
  logic [3:0]                 len2;
  logic [CALL_CHARS-1:0][2:0] pos_next;
  logic [3:0]                 len_next;

  // Stage three registers
  logic [CALL_CHARS-1:0][7:0] bytes3;
  logic [3:0]                 len3;
  logic [CALL_CHARS-1:0][7:0] bytes_next;

  // Stage four
  logic [2:0]                 last_idx;
  logic                       trim;
  logic [CALL_CHARS-1:0][7:0] trimmed;
  logic [63:0]                text_next;

  // Output slot of each kept character: count of kept ones before it
  always_comb begin
    len_next = '0;
    for (int k = 0; k < CALL_CHARS; k++) begin
      pos_next[k] = len_next[2:0];
      len_next = len_next + {3'b000, keep[k]};
    end
  end

  always_ff @(posedge clk) begin
    chars2 <= chars;
    keep2 <= keep;
    pos2 <= pos_next;
    len2 <= len_next;
  end

  // Gather characters into their slots
  always_comb begin
    bytes_next = '0;
    for (int j = 0; j < CALL_CHARS; j++) begin
      for (int k = 0; k < CALL_CHARS; k++) begin
        if (keep2[k] && (pos2[k] == 3'(j))) begin
          bytes_next[j] = bytes_next[j] | chars2[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes3 <= bytes_next;
    len3 <= len2;
  end

  // Drop a trailing '_'; a length of eight wraps to slot seven
  always_comb begin
    last_idx = len3[2:0] - 3'd1;
    trim = (len3 != 4'd0) && (bytes3[last_idx] == CHAR_SPACE);
    trimmed = bytes3;
    if (trim) begin
      trimmed[last_idx] = 8'h00;
    end
    for (int j = 0; j < CALL_CHARS; j++) begin
      text_next[63-8*j -: 8] = trimmed[j];
    end
  end

  always_ff @(posedge clk) begin
    callsign_text <= text_next;
    callsign_length <= trim ? (len3 - 4'd1) : len3;
  end

endmodule

@@ design/adsbd_fields.sv @@
// Numeric fields, stages two to four: altitude scaling, NIC and CPR pass,
// velocity components and vertical rate. Also carries class and codes.
// Depends on adsbd_pkg.
module adsbd_fields
  import adsbd_pkg::*;
(
  input  logic               clk,
  input  front_t             front,
  output logic [2:0]         msg_class,
  output logic [4:0]         type_code,
  output logic [2:0]         sub_code,
  output logic signed [16:0] altitude_ft,
  output logic [3:0]         nic,
  output logic [16:0]        cpr_lat,
  output logic [16:0]        cpr_lon,
  output logic signed [10:0] vel_east,
  output logic signed [10:0] vel_north,
  output logic signed [15:0] vert_rate
);

  // Stage two
  msg_class_t         cls2;
  logic [4:0]         tc2;
  logic [2:0]         sub2;
  logic               alt_en2;
  logic [15:0]        alt_prod2;
  logic [3:0]         nic2;
  logic [16:0]        lat2;
  logic [16:0]        lon2;
  logic signed [10:0] ew2;
  logic signed [10:0] ns2;
  logic               ew_neg2;
  logic               ns_neg2;
  logic signed [9:0]  vr2;
  logic               vr_neg2;

  // Stage three
  msg_class_t         cls3;
  logic [4:0]         tc3;
  logic [2:0]         sub3;
  logic signed [16:0] alt3;
  logic [3:0]         nic3;
  logic [16:0]        lat3;
  logic [16:0]        lon3;
  logic signed [10:0] ew3;
  logic signed [10:0] ns3;
  logic signed [15:0] vr3;
  logic signed [15:0] vr_scaled;

  // Altitude product, component magnitudes minus one (speed subtypes only)
  always_ff @(posedge clk) begin
    cls2 <= front.cls;
    tc2 <= front.tc;
    sub2 <= front.sub;
    alt_en2 <= front.alt_en;
    alt_prod2 <= 16'(front.alt_n) * 16'(ALT_STEP);
    nic2 <= front.nic;
    lat2 <= front.lat;
    lon2 <= front.lon;
    ew2 <= front.speed_sub ? ($signed({1'b0, front.ew_raw}) - 11'sd1)
                           : $signed({1'b0, front.ew_raw});
    ns2 <= front.speed_sub ? ($signed({1'b0, front.ns_raw}) - 11'sd1)
                           : $signed({1'b0, front.ns_raw});
    ew_neg2 <= front.speed_sub & front.ew_sign;
    ns_neg2 <= front.speed_sub & front.ns_sign;
    vr2 <= front.vel_en ? ($signed({1'b0, front.vr_raw}) - 10'sd1) : 10'sd0;
    vr_neg2 <= front.vel_en & front.vr_sign;
  end

  assign vr_scaled = 16'(vr2) <<< VR_SHIFT;

  // Altitude offset, sign application
  always_ff @(posedge clk) begin
    cls3 <= cls2;
    tc3 <= tc2;
    sub3 <= sub2;
    alt3 <= alt_en2 ? ($signed({1'b0, alt_prod2}) - 17'(ALT_OFFSET)) : -17'sd1;
    nic3 <= nic2;
    lat3 <= lat2;
    lon3 <= lon2;
    ew3 <= ew_neg2 ? -ew2 : ew2;
    ns3 <= ns_neg2 ? -ns2 : ns2;
    vr3 <= vr_neg2 ? -vr_scaled : vr_scaled;
  end

  // Output registers, aligned with the callsign path
  always_ff @(posedge clk) begin
    msg_class <= cls3;
    type_code <= tc3;
    sub_code <= sub3;
    altitude_ft <= alt3;
    nic <= nic3;
    cpr_lat <= lat3;
    cpr_lon <= lon3;
    vel_east <= ew3;
    vel_north <= ns3;
    vert_rate <= vr3;
  end

endmodule

@@ design/adsb_field_decoder.sv @@
// Top level of the DF17 extended squitter field decoder.
// Instantiates adsbd_classify, adsbd_callsign and adsbd_fields; uses adsbd_pkg.
//
// Usage:
//   Input: drive header and payload and raise start for one cycle per message.
//   A transaction is taken at each rising edge where start is high and busy is
//   low. busy is always low: the four-stage pipeline takes a message every cycle.
//   Output: every accepted message gives exactly one result, shown on the
//   result ports for one cycle with done high.
//   The pipeline stages are, in order: slicing and character mapping, slot
//   counting and altitude multiply, byte packing and sign handling,
//   trailing-space trim into the output registers.
//   Throughput is one message per cycle.
//   The receiver cannot stall; it must take each result in its done cycle.
//   Reset (rst, synchronous) clears the valid bits, dropping messages in
//   flight; no results appear until new messages arrive.
module adsb_field_decoder
  import adsbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         header,
  input  logic [55:0]        payload,
  output logic               done,
  output logic [2:0]         msg_class,
  output logic [4:0]         type_code,
  output logic [2:0]         sub_code,
  output logic [63:0]        callsign_text,
  output logic [3:0]         callsign_length,
  output logic signed [16:0] altitude_ft,
  output logic [3:0]         nic,
  output logic [16:0]        cpr_lat,
  output logic [16:0]        cpr_lon,
  output logic signed [10:0] vel_east,
  output logic signed [10:0] vel_north,
  output logic signed [15:0] vert_rate
);

  localparam int STAGES = 4;

  front_t             front;
  logic [STAGES-1:0]  valid;
  logic               accept;

  assign busy = 1'b0;
  assign accept = start && !busy;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[STAGES-2:0], accept};
    end
  end

  assign done = valid[STAGES-1];

  adsbd_classify u_classify (
    .clk     (clk),
    .header  (header),
    .payload (payload),
    .front   (front)
  );

  adsbd_callsign u_callsign (
    .clk             (clk),
    .chars           (front.chars),
    .keep            (front.keep),
    .callsign_text   (callsign_text),
    .callsign_length (callsign_length)
  );

  adsbd_fields u_fields (
    .clk         (clk),
    .front       (front),
    .msg_class   (msg_class),
    .type_code   (type_code),
    .sub_code    (sub_code),
    .altitude_ft (altitude_ft),
    .nic         (nic),
    .cpr_lat     (cpr_lat),
    .cpr_lon     (cpr_lon),
    .vel_east    (vel_east),
    .vel_north   (vel_north),
    .vert_rate   (vert_rate)
  );

  // Every accepted transaction yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted transaction gave no result");

  // No result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without a transaction");

  // Callsign appears only on identification results
  a_callsign_ident: assert property (@(posedge clk) disable iff (rst)
    done && (msg_class != CLS_IDENT) |-> (callsign_length == 4'd0) && (callsign_text == 64'd0))
    else $error("callsign on a non-ident result");

  // Unused text bytes are zero; an empty callsign has empty text
  a_empty_text: assert property (@(posedge clk) disable iff (rst)
    done && (callsign_length == 4'd0) |-> (callsign_text == 64'd0))
    else $error("text without characters");

  // Altitude and NIC only for airborne position
  a_alt_nic: assert property (@(posedge clk) disable iff (rst)
    done && (msg_class != CLS_AIR_POS) |-> (altitude_ft == -17'sd1) && (nic == NIC_NA))
    else $error("altitude or NIC outside airborne position");

endmodule
